// ----- sv/psc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and constants of the pressure sensor compensation unit
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int unsigned NUM_REGS = 6;

   typedef enum logic [2:0] {
      REG_C1 = 3'd0,
      REG_C2 = 3'd1,
      REG_C3 = 3'd2,
      REG_C4 = 3'd3,
      REG_C5 = 3'd4,
      REG_C6 = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [15:0] c1;
      logic [15:0] c2;
      logic [15:0] c3;
      logic [15:0] c4;
      logic [15:0] c5;
      logic [15:0] c6;
   } calib_type;

   // item held in the queue between front and back
   typedef struct packed {
      logic [23:0] d1;
      logic [23:0] d2;
   } sample_type;

   typedef struct packed {
      logic signed [31:0] temp;
      logic signed [31:0] press;
      logic [30:0]        depth;
      logic               taken;
   } result_type;

   localparam logic [30:0] DEPTH_MAX = 31'h7FFF_FFFF;
   localparam logic [16:0] DEPTH_SCALE = 17'd64945;

endpackage

// ----- sv/psc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_front
// input side: calibration registers and a two-entry sample queue
// ----------------------------------------------------------------------------
module psc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,
   output logic                 q_valid,
   input  logic                 q_ready,
   output psc_pkg::sample_type  q_data,
   output psc_pkg::calib_type   calib
);
   import psc_pkg::*;

   calib_type  calib_ff;
   sample_type buf_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign csr_ready  = 1'b1;
   assign calib      = calib_ff;
   assign req_tready = (cnt_ff != 2'd2);
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_data     = buf_ff[rd_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      rd_in  = pop ? ~rd_ff : rd_ff;
      wr_in  = push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
         calib_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
         if (csr_valid) begin
            case (reg_index_type'(csr_index))
               REG_C1:  calib_ff.c1 <= csr_data;
               REG_C2:  calib_ff.c2 <= csr_data;
               REG_C3:  calib_ff.c3 <= csr_data;
               REG_C4:  calib_ff.c4 <= csr_data;
               REG_C5:  calib_ff.c5 <= csr_data;
               REG_C6:  calib_ff.c6 <= csr_data;
               default: ;
            endcase
         end
      end
      if (push) begin
         buf_ff[wr_ff].d1 <= req_tdata[23:0];
         buf_ff[wr_ff].d2 <= req_tdata[47:24];
      end
   end
endmodule

// ----- sv/psc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_back
// compensation pipeline with per-stage valid bits and a whole-pipeline stall
// ----------------------------------------------------------------------------
module psc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  psc_pkg::sample_type  q_data,
   input  psc_pkg::calib_type   calib,
   output logic                 out_valid,
   input  logic                 out_ready,
   output psc_pkg::result_type  out_data
);
   import psc_pkg::*;

   localparam int NST = 9;
   logic [NST-1:0] v_ff;
   logic           adv;

   // pipeline moves whole when the last stage is free
   assign adv     = !v_ff[NST-1] || out_ready;
   assign q_ready = adv;
   assign out_valid = v_ff[NST-1];

   // stage 1: dt
   logic signed [25:0] s1_dt_ff;
   logic [23:0]        s1_d1_ff;
   // stage 2: products
   logic signed [42:0] s2_dtc6_ff;
   logic signed [42:0] s2_c4dt_ff;
   logic signed [42:0] s2_c3dt_ff;
   logic signed [51:0] s2_dtdt_ff;
   logic [23:0]        s2_d1_ff;
   // stage 3: temp, off, sens first order, ti
   logic signed [31:0] s3_temp_ff;
   logic signed [37:0] s3_off_ff;
   logic signed [36:0] s3_sens_ff;
   logic signed [20:0] s3_ti_ff;
   logic [23:0]        s3_d1_ff;
   // stage 4: td, vl squares
   logic signed [31:0] s4_temp_ff;
   logic signed [63:0] s4_tdsq_ff;
   logic signed [63:0] s4_vlsq_ff;
   logic               s4_low_ff, s4_vlow_ff;
   logic signed [37:0] s4_off_ff;
   logic signed [36:0] s4_sens_ff;
   logic signed [20:0] s4_ti_ff;
   logic [23:0]        s4_d1_ff;
   // stage 5: corrected values
   logic signed [31:0] s5_temp_ff;
   logic signed [63:0] s5_off_ff;
   logic signed [63:0] s5_sens_ff;
   logic [23:0]        s5_d1_ff;
   // stage 6: d1*sens
   logic signed [31:0] s6_temp_ff;
   logic signed [63:0] s6_off_ff;
   logic signed [63:0] s6_prod_ff;
   // stage 7: pressure
   logic signed [31:0] s7_temp_ff;
   logic signed [31:0] s7_press_ff;
   // stage 8: reference and difference
   logic signed [31:0] s8_temp_ff, s8_press_ff;
   logic signed [32:0] s8_dp_ff;
   logic               s8_taken_ff;
   logic signed [31:0] surf_ff;
   logic               surf_valid_ff;
   result_type         s9_ff;

   // truncating signed division by a power of two
   function automatic logic signed [63:0] sdiv(input logic signed [63:0] a,
                                                input int unsigned sh);
      logic signed [63:0] bias;
      bias = a[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
      return (a + bias) >>> sh;
   endfunction

   always_comb begin
      out_data = s9_ff;
   end

   logic signed [63:0] t3_temp, t3_off, t3_sens, t3_ti;
   logic signed [31:0] t4_td, t4_vl;
   logic signed [39:0] t4_tdsq, t4_vlsq;
   logic signed [63:0] t5_offi, t5_sensi;
   logic signed [63:0] t6_prod;
   logic signed [63:0] t7_p;
   logic signed [31:0] t8_ref;
   logic signed [49:0] t9_prod;
   logic [33:0]        t9_dep;

   always_comb begin
      t3_temp = 64'sd2000 + sdiv(64'(s2_dtc6_ff), 23);
      t3_off  = $signed({26'd0, calib.c2, 16'd0}) + sdiv(64'(s2_c4dt_ff), 7);
      t3_sens = $signed({33'd0, calib.c1, 15'd0}) + sdiv(64'(s2_c3dt_ff), 8);
      t3_ti   = (t3_temp < 64'sd2000)
              ? sdiv(64'(s2_dtdt_ff) * 64'sd3, 33)
              : sdiv(64'(s2_dtdt_ff) * 64'sd2, 37);
      // td and vl stay within 20 signed bits over the whole input range
      t4_td   = s3_temp_ff - 32'sd2000;
      t4_vl   = s3_temp_ff + 32'sd1500;
      t4_tdsq = $signed(t4_td[19:0]) * $signed(t4_td[19:0]);
      t4_vlsq = $signed(t4_vl[19:0]) * $signed(t4_vl[19:0]);
      if (s4_low_ff) begin
         t5_offi  = sdiv(s4_tdsq_ff * 64'sd3, 1);
         t5_sensi = sdiv(s4_tdsq_ff * 64'sd5, 3);
         if (s4_vlow_ff) begin
            t5_offi  = t5_offi + s4_vlsq_ff * 64'sd7;
            t5_sensi = t5_sensi + (s4_vlsq_ff <<< 2);
         end
      end else begin
         t5_offi  = sdiv(s4_tdsq_ff, 4);
         t5_sensi = 64'sd0;
      end
      // sens always fits 40 signed bits
      t6_prod = $signed({1'b0, s5_d1_ff}) * $signed(s5_sens_ff[39:0]);
      t7_p   = sdiv(sdiv(s6_prod_ff, 21) - s6_off_ff, 13);
      t8_ref = surf_valid_ff ? surf_ff : s7_press_ff;
      t9_prod = 50'(s8_dp_ff) * $signed({33'd0, DEPTH_SCALE});
      t9_dep  = t9_prod[49:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         surf_valid_ff <= 1'b0;
         surf_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], q_valid};
         if (v_ff[6] && !surf_valid_ff) begin
            surf_valid_ff <= 1'b1;
            surf_ff <= s7_press_ff;
         end
      end
      if (adv) begin
         s1_dt_ff <= $signed({2'b0, q_data.d2}) - $signed({2'b0, calib.c5, 8'd0});
         s1_d1_ff <= q_data.d1;

         s2_dtc6_ff <= 43'(s1_dt_ff) * $signed({27'd0, calib.c6});
         s2_c4dt_ff <= 43'(s1_dt_ff) * $signed({27'd0, calib.c4});
         s2_c3dt_ff <= 43'(s1_dt_ff) * $signed({27'd0, calib.c3});
         s2_dtdt_ff <= 52'(s1_dt_ff) * 52'(s1_dt_ff);
         s2_d1_ff   <= s1_d1_ff;

         s3_temp_ff <= t3_temp[31:0];
         s3_off_ff  <= t3_off[37:0];
         s3_sens_ff <= t3_sens[36:0];
         s3_ti_ff   <= t3_ti[20:0];
         s3_d1_ff   <= s2_d1_ff;

         s4_temp_ff <= s3_temp_ff;
         s4_tdsq_ff <= 64'(t4_tdsq);
         s4_vlsq_ff <= 64'(t4_vlsq);
         s4_low_ff  <= s3_temp_ff < 32'sd2000;
         s4_vlow_ff <= s3_temp_ff < -32'sd1500;
         s4_off_ff  <= s3_off_ff;
         s4_sens_ff <= s3_sens_ff;
         s4_ti_ff   <= s3_ti_ff;
         s4_d1_ff   <= s3_d1_ff;

         s5_temp_ff <= s4_temp_ff - 32'(s4_ti_ff);
         s5_off_ff  <= 64'(s4_off_ff) - t5_offi;
         s5_sens_ff <= 64'(s4_sens_ff) - t5_sensi;
         s5_d1_ff   <= s4_d1_ff;

         s6_temp_ff <= s5_temp_ff;
         s6_off_ff  <= s5_off_ff;
         s6_prod_ff <= t6_prod;

         s7_temp_ff  <= s6_temp_ff;
         s7_press_ff <= t7_p[31:0];

         s8_temp_ff  <= s7_temp_ff;
         s8_press_ff <= s7_press_ff;
         s8_dp_ff    <= 33'(s7_press_ff) - 33'(t8_ref);
         s8_taken_ff <= !surf_valid_ff;

         s9_ff.temp  <= s8_temp_ff;
         s9_ff.press <= s8_press_ff;
         s9_ff.taken <= s8_taken_ff;
         if (s8_dp_ff <= 33'sd0)
            s9_ff.depth <= '0;
         else if (t9_dep > 34'(DEPTH_MAX))
            s9_ff.depth <= DEPTH_MAX;
         else
            s9_ff.depth <= t9_dep[30:0];
      end
   end
endmodule

// ----- sv/pressure_sensor_compensation_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_unit
// second-order pressure and temperature compensation with depth
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req_    | in  | tdata: raw_pressure[23:0], raw_temperature[47:24]
//  rsp_    | out | tdata: temperature, pressure, depth[94:64]; tuser: taken
//  csr_    | in  | csr_index (register), csr_data (16-bit word)
//
//  one item per cycle sustained while rsp_ is ready; the back pipeline is a
//  chain of multipliers, each followed by a register
//  reset clears calibration words, surface reference and the queue
//  a stall on rsp_ freezes the back pipeline; req_ keeps accepting until
//  the two-entry queue is full
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // raw_pressure, raw_temperature
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // temperature_centi_c, pressure_tenth_mbar, depth_mm
   output logic        rsp_tuser,   // reference_taken
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import psc_pkg::*;

   logic       q_valid, q_ready;
   sample_type q_data;
   calib_type  calib;
   result_type res;

   // front: registers and queue
   psc_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_ready, .q_data, .calib
   );

   // back: compensation arithmetic
   psc_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data, .calib,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(res)
   );

   assign rsp_tdata = {1'b0, res.depth, res.press, res.temp};
   assign rsp_tuser = res.taken;
endmodule
